// ----- hw/rtl/rsd_pkg.sv -----
// Shared types and constants for the descending record sorter.
// No dependencies; used by the sort cell, the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  // default chain length, one record per cell
  localparam int MAX_RECORDS_DEF = 64;

  localparam int KEY_W = 24;
  localparam int TAG_W = 16;
  // load position within a set; the user must keep the chain within the default length (not enforced)
  localparam int SEQ_W = $clog2(MAX_RECORDS_DEF);

  // one record as it is loaded
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // one record as it moves along the chain, tagged with its load position
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
  } cell_rec_t;

  // control that the core broadcasts to every cell
  typedef struct packed {
    logic drain;  // shift held records toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/record_sort_by_key_descending_core.sv -----
// After the word marked set_end is taken, the chain settles in the flush state and
// the sorted words follow, one sorted word per cycle while out_stall is low.
// Throughput: one record per cycle while loading; in_stall is high from set_end
// until the last sorted word is taken, while the chain settles and drains.
// The chain length MAX_RECORDS sets both the settling time and the capacity.
// Reset (rst, synchronous) empties the chain and clears count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module record_sort_by_key_descending_core
  import rsd_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] key_cents,
  input  wire logic [TAG_W-1:0] record_tag,
  input  wire logic             set_end,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [KEY_W-1:0] sorted_key,
  output logic      [TAG_W-1:0] sorted_tag,
  output logic                  final_result,
  output logic                  overflowed
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] flush_cnt;
  logic             overflow_seen;

  logic      in_acc, out_acc, room;
  cell_ctl_t ctl;

  logic      hv [MAX_RECORDS];
  cell_rec_t hr [MAX_RECORDS];
  logic      pv [MAX_RECORDS];
  cell_rec_t pr [MAX_RECORDS];
  cell_rec_t in_rec;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign room     = (held_count < CNT_W'(MAX_RECORDS));

  assign in_rec.key = key_cents;
  assign in_rec.tag = record_tag;
  // load position breaks key ties
  assign in_rec.seq = SEQ_W'(held_count);

  assign ctl.drain = (state == ST_DRAIN) && !out_stall;

  // chain of cells; cell 0 holds the largest key
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic      a_valid, n_valid;
    cell_rec_t a_rec, n_rec;
    if (i == 0) begin : g_head
      assign a_valid = in_acc && room;
      assign a_rec   = in_rec;
    end else begin : g_body
      assign a_valid = pv[i-1];
      assign a_rec   = pr[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_rec   = hr[i];
    end else begin : g_inner
      assign n_valid = hv[i+1];
      assign n_rec   = hr[i+1];
    end
    rsd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .arr_valid (a_valid),
      .arr_rec   (a_rec),
      .nbr_valid (n_valid),
      .nbr_rec   (n_rec),
      .held_valid(hv[i]),
      .held_rec  (hr[i]),
      .pass_valid(pv[i]),
      .pass_rec  (pr[i])
    );
  end

  // results come straight from the head cell
  assign out_valid    = (state == ST_DRAIN);
  assign sorted_key   = hr[0].key;
  assign sorted_tag   = hr[0].tag;
  assign final_result = !hv[1];
  assign overflowed   = overflow_seen;

  // set sequencing: load, let the chain settle, drain
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      held_count    <= '0;
      flush_cnt     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              held_count <= held_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (set_end) begin
              state     <= ST_FLUSH;
              flush_cnt <= CNT_W'(MAX_RECORDS - 1);
            end
          end
        end
        ST_FLUSH: begin
          if (flush_cnt == '0) begin
            state <= ST_DRAIN;
          end else begin
            flush_cnt <= flush_cnt - CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (out_acc && final_result) begin
            state         <= ST_LOAD;
            held_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rsd_cell.sv -----
// One cell of the insertion chain: holds one record, passes the loser on.
// Depends on rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsd_cell
  import rsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  // record arriving from the upstream neighbor
  input  wire logic      arr_valid,
  input  wire cell_rec_t arr_rec,
  // held record of the downstream neighbor, taken while draining
  input  wire logic      nbr_valid,
  input  wire cell_rec_t nbr_rec,
  output logic           held_valid,
  output cell_rec_t      held_rec,
  output logic           pass_valid,
  output cell_rec_t      pass_rec
);

  // larger key wins; on equal keys the earlier loaded record wins, so a
  // displaced record still lands ahead of later ones with the same key
  logic wins;
  assign wins = !held_valid || (arr_rec.key > held_rec.key) ||
                ((arr_rec.key == held_rec.key) && (arr_rec.seq < held_rec.seq));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctl.drain) begin
      held_valid <= nbr_valid;
      pass_valid <= 1'b0;
    end else if (arr_valid) begin
      held_valid <= 1'b1;
      pass_valid <= held_valid;
    end else begin
      pass_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      held_rec <= nbr_rec;
    end else if (arr_valid) begin
      if (wins) begin
        held_rec <= arr_rec;
        pass_rec <= held_rec;
      end else begin
        pass_rec <= arr_rec;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rsd_checker.sv -----
// Port-level checks for the descending record sorter, bound to the core.
// Depends on rsd_pkg and record_sort_by_key_descending_core.
`timescale 1ns / 1ps
`default_nettype none

module rsd_checker
  import rsd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [KEY_W-1:0] sorted_key,
  input wire logic             final_result
);

  // no record is taken while sorted words are offered
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // a taken word that is not the last is followed by one with a key no larger
  a_descending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !final_result) |=>
      (out_valid && (sorted_key <= $past(sorted_key))))
    else $error("results not in descending order");

  // the last word of a set ends the output burst
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_result) |=> !out_valid)
    else $error("output continues after final word");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sorted_key)))
    else $error("stalled output word changed");

endmodule

bind record_sort_by_key_descending_core rsd_checker u_rsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sorted_key  (sorted_key),
  .final_result(final_result)
);

`default_nettype wire
